// ===== design/serial_frame_builder_macros.svh =====
// Assertion helpers for the framer design; only serial_frame_builder.sv includes them.
`ifndef SERIAL_FRAME_BUILDER_MACROS_SVH
`define SERIAL_FRAME_BUILDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sfb_pkg.sv =====
package sfb_pkg;

  localparam int unsigned MaxPayload = 1024;

  localparam int unsigned SeqW   = 16;
  localparam int unsigned LenW   = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned InDataW = SeqW + LenW + ByteW;

  localparam logic ReqStart = 1'b0;
  localparam logic ReqData  = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgStartCode   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgStopCode    = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgCommandCode = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgTypeCode    = 8'd3;

  typedef enum logic [3:0] {
    SLOT_START  = 4'd0,
    SLOT_CMD    = 4'd1,
    SLOT_TYPE   = 4'd2,
    SLOT_LEN0   = 4'd3,
    SLOT_LEN1   = 4'd4,
    SLOT_LEN2   = 4'd5,
    SLOT_LEN3   = 4'd6,
    SLOT_SEQ0   = 4'd7,
    SLOT_SEQ1   = 4'd8,
    SLOT_DATA   = 4'd9,
    SLOT_SUM    = 4'd10,
    SLOT_STOP   = 4'd11,
    SLOT_REJECT = 4'd12
  } slot_e;

  typedef struct packed {
    logic [ByteW-1:0] start_code;
    logic [ByteW-1:0] stop_code;
    logic [ByteW-1:0] command_code;
    logic [ByteW-1:0] type_code;
  } codes_t;

  typedef struct packed {
    slot_e            first;
    slot_e            last;
    logic [LenW-1:0]  len;
    logic [SeqW-1:0]  seq;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] sum;
  } job_t;

endpackage

// ===== design/sfb_emitter.sv =====
module sfb_emitter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_load_i,
  input  sfb_pkg::job_t             job_i,
  input  sfb_pkg::codes_t           codes_i,
  output logic                      free_o,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [sfb_pkg::ByteW-1:0] m_axis_tdata,  // out_byte
  output logic                      m_axis_tlast,  // run_last
  output logic                      m_axis_tuser   // rejected
);

  logic           valid_q;
  sfb_pkg::job_t  job_q;
  sfb_pkg::slot_e slot_q, slot_d;
  logic           fire;
  logic           at_last;

  assign fire    = valid_q && m_axis_tready;
  assign at_last = (slot_q == job_q.last);
  assign free_o  = !valid_q || (fire && at_last);

  always_comb begin
    if (slot_q == sfb_pkg::SLOT_SEQ1) begin
      slot_d = sfb_pkg::SLOT_SUM;
    end else begin
      slot_d = sfb_pkg::slot_e'(slot_q + 4'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (job_load_i) begin
      valid_q <= 1'b1;
    end else if (fire && at_last) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load_i) begin
      job_q  <= job_i;
      slot_q <= job_i.first;
    end else if (fire && !at_last) begin
      slot_q <= slot_d;
    end
  end

  always_comb begin
    case (slot_q)
      sfb_pkg::SLOT_START: m_axis_tdata = codes_i.start_code;
      sfb_pkg::SLOT_CMD:   m_axis_tdata = codes_i.command_code;
      sfb_pkg::SLOT_TYPE:  m_axis_tdata = codes_i.type_code;
      sfb_pkg::SLOT_LEN0:  m_axis_tdata = job_q.len[7:0];
      sfb_pkg::SLOT_LEN1:  m_axis_tdata = job_q.len[15:8];
      sfb_pkg::SLOT_SEQ0:  m_axis_tdata = job_q.seq[7:0];
      sfb_pkg::SLOT_SEQ1:  m_axis_tdata = job_q.seq[15:8];
      sfb_pkg::SLOT_DATA:  m_axis_tdata = job_q.data;
      sfb_pkg::SLOT_SUM:   m_axis_tdata = job_q.sum;
      sfb_pkg::SLOT_STOP:  m_axis_tdata = codes_i.stop_code;
      default:             m_axis_tdata = '0;
    endcase
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = at_last;
  assign m_axis_tuser  = (slot_q == sfb_pkg::SLOT_REJECT);

endmodule

// ===== design/serial_frame_builder.sv =====
// The first byte of a transaction is offered in the cycle after it is accepted.
// One byte per cycle while m_axis_tready is high; a payload byte gives one output byte, a closing
// payload byte three, a frame start nine, or eleven with zero length, and a refused start one.
// The next input is taken in the cycle that the current job's last byte leaves.
// Reset clears the four code registers, the frame state and the output valid.
`include "serial_frame_builder_macros.svh"

module serial_frame_builder #(
  parameter int unsigned MAX_PAYLOAD = sfb_pkg::MaxPayload
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [sfb_pkg::InDataW-1:0] s_axis_tdata,  // seq_num, payload_length, data_byte
  input  logic                        s_axis_tuser,  // req_type
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [sfb_pkg::ByteW-1:0]   m_axis_tdata,  // out_byte
  output logic                        m_axis_tlast,  // run_last
  output logic                        m_axis_tuser,  // rejected
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [sfb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sfb_pkg::ByteW-1:0]   cfg_data_i
);

  localparam int unsigned BlW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [sfb_pkg::LenW-1:0] MaxLen = sfb_pkg::LenW'(MAX_PAYLOAD);

  sfb_pkg::codes_t            codes_q;
  logic                       in_frame_q, in_frame_d;
  logic [BlW-1:0]             bytes_left_q, bytes_left_d;
  logic [sfb_pkg::ByteW-1:0]  sum_q, sum_d, sum_next;
  logic                       free;
  logic                       s_accept;
  logic                       job_valid;
  sfb_pkg::job_t              job;
  logic [sfb_pkg::SeqW-1:0]   in_seq;
  logic [sfb_pkg::LenW-1:0]   in_len;
  logic [sfb_pkg::ByteW-1:0]  in_dat;

  assign in_seq = s_axis_tdata[sfb_pkg::SeqW-1:0];
  assign in_len = s_axis_tdata[sfb_pkg::SeqW +: sfb_pkg::LenW];
  assign in_dat = s_axis_tdata[sfb_pkg::SeqW + sfb_pkg::LenW +: sfb_pkg::ByteW];

  assign s_axis_tready = free;
  assign s_accept      = s_axis_tvalid && free;
  assign cfg_ready_o   = 1'b1;
  assign sum_next      = sum_q + in_dat;

  always_comb begin
    in_frame_d   = in_frame_q;
    bytes_left_d = bytes_left_q;
    sum_d        = sum_q;
    job_valid    = 1'b0;
    job.first    = sfb_pkg::SLOT_REJECT;
    job.last     = sfb_pkg::SLOT_REJECT;
    job.len      = in_len;
    job.seq      = in_seq;
    job.data     = in_dat;
    job.sum      = '0;
    if (s_axis_tuser == sfb_pkg::ReqStart) begin
      job_valid = 1'b1;
      sum_d     = '0;
      if (in_len > MaxLen) begin
        in_frame_d   = 1'b0;
        bytes_left_d = '0;
      end else begin
        in_frame_d   = (in_len != '0);
        bytes_left_d = in_len[BlW-1:0];
        job.first    = sfb_pkg::SLOT_START;
        job.last     = (in_len == '0) ? sfb_pkg::SLOT_STOP : sfb_pkg::SLOT_SEQ1;
      end
    end else begin
      if (!in_frame_q || bytes_left_q == '0) begin
        in_frame_d = 1'b0;
      end else begin
        job_valid    = 1'b1;
        sum_d        = sum_next;
        bytes_left_d = bytes_left_q - BlW'(1);
        job.first    = sfb_pkg::SLOT_DATA;
        job.sum      = sum_next;
        if (bytes_left_q == BlW'(1)) begin
          in_frame_d = 1'b0;
          job.last   = sfb_pkg::SLOT_STOP;
        end else begin
          job.last = sfb_pkg::SLOT_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q      <= '0;
      in_frame_q   <= 1'b0;
      bytes_left_q <= '0;
      sum_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          sfb_pkg::CfgStartCode:   codes_q.start_code   <= cfg_data_i;
          sfb_pkg::CfgStopCode:    codes_q.stop_code    <= cfg_data_i;
          sfb_pkg::CfgCommandCode: codes_q.command_code <= cfg_data_i;
          sfb_pkg::CfgTypeCode:    codes_q.type_code    <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_accept) begin
        in_frame_q   <= in_frame_d;
        bytes_left_q <= bytes_left_d;
        sum_q        <= sum_d;
      end
    end
  end

  sfb_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_load_i    (s_accept && job_valid),
    .job_i         (job),
    .codes_i       (codes_q),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  `SFB_ASSERT_NOW(a_reject_single, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
                  m_axis_tlast, "refused start must be a single byte")
  `SFB_ASSERT_NOW(a_frame_has_bytes, clk_i, rst_ni, in_frame_q, bytes_left_q != '0,
                  "open frame with no bytes left")
  `SFB_ASSERT_NOW(a_accept_when_free, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
                  !m_axis_tvalid || (m_axis_tready && m_axis_tlast),
                  "input taken while a job is still pending")
  `SFB_ASSERT_NEXT(a_close_on_last, clk_i, rst_ni,
                   s_accept && s_axis_tuser == sfb_pkg::ReqData && in_frame_q &&
                   bytes_left_q == BlW'(1),
                   !in_frame_q && m_axis_tvalid, "frame not closed after last payload byte")

endmodule
